### design/btlv_pkg.sv
// Shared types, codes and helpers for the BER TLV stream parser.
// Used by every module in the design folder; depends on nothing else.
package btlv_pkg;

   localparam int MaxDepth     = 16;
   localparam int MaxLenOctets = 4;
   localparam int QDepth       = 4;
   localparam int QAw          = $clog2(QDepth);

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_CLOSED = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TABLE     = 3'd1;
   localparam logic [2:0] ERR_OVERRUN   = 3'd2;
   localparam logic [2:0] ERR_INTEGER   = 3'd3;
   localparam logic [2:0] ERR_NULL      = 3'd4;
   localparam logic [2:0] ERR_LENGTH    = 3'd5;
   localparam logic [2:0] ERR_TOO_DEEP  = 3'd6;

   localparam logic [7:0] TAG_INTEGER = 8'h02;
   localparam logic [7:0] TAG_NULL    = 8'h05;
   localparam logic [7:0] LEN_INDEF   = 8'h80;
   localparam logic [7:0] OCTET_ONES  = 8'hFF;

   typedef enum logic [7:0] {
      PH_ID      = 8'b0000_0001,
      PH_TAGX    = 8'b0000_0010,
      PH_LEN1    = 8'b0000_0100,
      PH_LENX    = 8'b0000_1000,
      PH_CONTENT = 8'b0001_0000,
      PH_SCAN    = 8'b0010_0000,
      PH_EOC2    = 8'b0100_0000,
      PH_HALT    = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [32:0] end_off;
      logic        indef;
      logic [7:0]  tag;
      logic [15:0] entry;
   } stk_entry_type;

   typedef struct packed {
      logic [31:0] p;
      logic [32:0] q;
      logic [32:0] hend;
   } cell_bus_type;

   typedef struct packed {
      logic over_p;
      logic over_h;
      logic pop;
   } cell_stat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tag;
      logic [4:0]  nest;
      logic [31:0] offset;
      logic [31:0] len;
      logic        indef;
      logic [15:0] idx;
      logic [2:0]  err;
      logic        last;
   } rec_type;

   function automatic rec_type make_rec(input logic [1:0] kind, input logic [7:0] tag,
                                        input logic [4:0] nest, input logic [31:0] offset,
                                        input logic [31:0] len, input logic indef,
                                        input logic [15:0] idx, input logic [2:0] err);
      rec_type r;
      r.kind   = kind;
      r.tag    = tag;
      r.nest   = nest;
      r.offset = offset;
      r.len    = len;
      r.indef  = indef;
      r.idx    = idx;
      r.err    = err;
      r.last   = 1'b0;
      return r;
   endfunction

endpackage

### design/btlv_cell.sv
// One level of the nesting stack: holds its end offset and checks it against the byte stream.
// Depends on btlv_pkg; chained by the top level, each cell passing its pop flag downward.
module btlv_cell #(
   parameter int MAX_DEPTH = btlv_pkg::MaxDepth,
   parameter int LW        = $clog2(MAX_DEPTH + 1),
   parameter int IDX       = 0
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  btlv_pkg::stk_entry_type wr_data,
   input  logic [LW-1:0]           level,
   input  logic [LW-1:0]           chain_level,
   input  btlv_pkg::cell_bus_type  bus,
   input  logic                    pop_above,
   output btlv_pkg::stk_entry_type entry,
   output btlv_pkg::cell_stat_type stat
);

   btlv_pkg::stk_entry_type entry_ff;
   logic                    active;
   logic                    chain_active;
   logic                    chain_top;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_data;
      end
   end

   assign active       = (LW'(IDX) < level) && !entry_ff.indef;
   assign chain_active = (LW'(IDX) < chain_level) && !entry_ff.indef;
   assign chain_top    = ((LW + 1)'(IDX + 1) >= {1'b0, chain_level});

   assign stat.over_p = active && ({1'b0, bus.p} >= entry_ff.end_off);
   assign stat.over_h = active && (bus.hend > entry_ff.end_off);
   assign stat.pop    = chain_active && (entry_ff.end_off == bus.q) && (chain_top || pop_above);
   assign entry       = entry_ff;

endmodule

### design/btlv_outq.sv
// Small record queue between the parser core and the result channel.
// Depends on btlv_pkg; takes up to two records per cycle and gives out one per cycle while out_ready is high.
module btlv_outq (
   input  logic              clock,
   input  logic              reset,
   input  btlv_pkg::rec_type in_rec0,
   input  btlv_pkg::rec_type in_rec1,
   input  logic [1:0]        in_count,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output btlv_pkg::rec_type out_rec
);

   localparam int CW = btlv_pkg::QAw + 1;

   btlv_pkg::rec_type            mem [btlv_pkg::QDepth];
   logic [btlv_pkg::QAw-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_rec   = mem[head_ff];
   assign room      = (count_ff <= CW'(btlv_pkg::QDepth - 2));

   always_comb begin
      head_in  = head_ff + btlv_pkg::QAw'(pop);
      tail_in  = tail_ff + btlv_pkg::QAw'(in_count);
      count_in = count_ff + CW'(in_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_count != 2'd0) begin
         mem[tail_ff] <= in_rec0;
      end
      if (in_count == 2'd2) begin
         mem[tail_ff + btlv_pkg::QAw'(1)] <= in_rec1;
      end
   end

endmodule

### design/ber_tlv_stream_parser.sv
// Top level of the BER TLV stream parser: byte decoder, chain of stack cells, record queue.
// Depends on btlv_pkg, btlv_cell and btlv_outq.
// A record is written into the record queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while req_tready is high; req_tready drops while the
// four-record queue has fewer than two free slots.
// Reset is synchronous; it clears the parse state, the CSRs and the queue, stack cells are not cleared.
module ber_tlv_stream_parser #(
   parameter int MAX_DEPTH      = btlv_pkg::MaxDepth,
   parameter int MAX_LEN_OCTETS = btlv_pkg::MaxLenOctets
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // start_req
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // tag_byte, nest_level, item_offset, content_length,
                                     // indefinite, entry_index, error_code, zero fill
   output logic [1:0]   rsp_tuser,   // record_kind
   output logic         rsp_tlast,   // last
   input  logic         csr_wen,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int LW  = $clog2(MAX_DEPTH + 1);
   localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int LLW = $clog2(MAX_LEN_OCTETS + 1);

   btlv_pkg::phase_type     phase_ff, phase_in, e_phase;
   logic [7:0]              tag_ff, tag_in, e_tag;
   logic [LLW-1:0]          left_ff, left_in;
   logic [31:0]             acc_ff, acc_in;
   logic [31:0]             off_ff, off_in, e_off;
   logic [31:0]             start_ff, start_in, e_start;
   logic [LW-1:0]           level_ff, level_in, e_level;
   logic [15:0]             count_ff, count_in, e_count;
   logic                    pz_ff, pz_in;
   logic [1:0]              ipos_ff, ipos_in;
   logic [7:0]              ifirst_ff, ifirst_in;
   logic [15:0]             cur_ff, cur_in;
   logic [31:0]             total_ff;
   logic [15:0]             limit_ff;

   logic                    accept, start;
   logic [7:0]              b;
   logic [31:0]             p;
   logic [32:0]             q;
   logic [31:0]             acc_sh;
   logic [31:0]             hd_len;
   logic                    close_now;
   logic [LW-1:0]           chain_level, new_level;
   btlv_pkg::cell_bus_type  bus;
   btlv_pkg::cell_stat_type stats [MAX_DEPTH];
   btlv_pkg::stk_entry_type ents [MAX_DEPTH];
   btlv_pkg::stk_entry_type top_e, push_data;
   logic [MAX_DEPTH:0]      pops;
   logic [MAX_DEPTH-1:0]    overp_v, overh_v;
   logic                    over_p, over_h;
   logic                    push_en;

   logic                    lf, hd, hd_indef, do_close, fin, pushes, constructed, fail3;
   logic [31:0]             eoc_at;
   logic [LW-1:0]           t_level;
   btlv_pkg::rec_type       rec0, rec1;
   logic [1:0]              nrec;
   btlv_pkg::rec_type       out_rec;
   logic                    q_room;

   assign accept  = req_tvalid && req_tready;
   assign start   = req_tuser;
   assign b       = req_tdata;
   assign e_phase = start ? btlv_pkg::PH_ID : phase_ff;
   assign e_tag   = start ? 8'd0 : tag_ff;
   assign e_off   = start ? 32'd0 : off_ff;
   assign e_start = start ? 32'd0 : start_ff;
   assign e_level = start ? '0 : level_ff;
   assign e_count = start ? 16'd0 : count_ff;

   assign p      = e_off;
   assign q      = {1'b0, p} + 33'd1;
   assign acc_sh = {acc_ff[23:0], b};
   assign hd_len = (e_phase == btlv_pkg::PH_LENX) ? acc_sh : {24'd0, b};

   assign bus.p    = p;
   assign bus.q    = q;
   assign bus.hend = q + {1'b0, hd_len};

   assign close_now = ((e_phase == btlv_pkg::PH_EOC2) && (b == 8'd0) && (e_level != '0))
                   || ((e_phase == btlv_pkg::PH_SCAN) && pz_ff && (b == 8'd0));
   assign chain_level = close_now ? (e_level - LW'(1)) : e_level;
   assign top_e       = ents[IW'(e_level - LW'(1))];
   assign pops[MAX_DEPTH] = 1'b0;

   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      btlv_cell #(.MAX_DEPTH(MAX_DEPTH), .LW(LW), .IDX(i)) u_cell (
         .clock       (clock),
         .wr_en       (push_en && accept && (level_ff == LW'(i) || start) && (e_level == LW'(i))),
         .wr_data     (push_data),
         .level       (e_level),
         .chain_level (chain_level),
         .bus         (bus),
         .pop_above   (pops[i+1]),
         .entry       (ents[i]),
         .stat        (stats[i])
      );
      assign pops[i]    = stats[i].pop;
      assign overp_v[i] = stats[i].over_p;
      assign overh_v[i] = stats[i].over_h;
   end

   assign over_p = (|overp_v) || ((total_ff != 32'd0) && (p >= total_ff));
   assign over_h = (|overh_v) || ((total_ff != 32'd0) && (bus.hend > {1'b0, total_ff}));

   always_comb begin
      new_level = chain_level;
      for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
         if (pops[i]) begin
            new_level = LW'(i);
         end
      end
   end

   always_comb begin
      phase_in  = e_phase;
      tag_in    = e_tag;
      left_in   = left_ff;
      acc_in    = acc_ff;
      off_in    = e_off;
      start_in  = e_start;
      level_in  = e_level;
      count_in  = e_count;
      pz_in     = pz_ff;
      ipos_in   = ipos_ff;
      ifirst_in = ifirst_ff;
      cur_in    = cur_ff;
      rec0      = '0;
      rec1      = '0;
      nrec      = 2'd0;
      lf        = 1'b0;
      hd        = 1'b0;
      hd_indef  = 1'b0;
      do_close  = 1'b0;
      fin       = 1'b0;
      fail3     = 1'b0;
      eoc_at    = e_start;
      push_en   = 1'b0;
      t_level   = e_level - LW'(1);
      constructed = e_tag[5];
      pushes    = 1'b0;
      push_data = '0;
      if (e_phase != btlv_pkg::PH_HALT) begin
         off_in = p + 32'd1;
         if (over_p) begin
            rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_ERROR, e_tag, 5'(e_level), e_start, 32'd0,
                      1'b0, (e_phase == btlv_pkg::PH_CONTENT) ? cur_ff : e_count,
                      btlv_pkg::ERR_OVERRUN);
            nrec = 2'd1;
            phase_in = btlv_pkg::PH_HALT;
         end else begin
            unique case (e_phase)
               btlv_pkg::PH_ID: begin
                  start_in = p;
                  tag_in   = b;
                  if ((b == 8'd0) && ((e_level != '0) ? top_e.indef : (total_ff == 32'd0))) begin
                     phase_in = btlv_pkg::PH_EOC2;
                  end else if (b[4:0] == 5'h1F) begin
                     phase_in = btlv_pkg::PH_TAGX;
                  end else begin
                     phase_in = btlv_pkg::PH_LEN1;
                  end
               end
               btlv_pkg::PH_TAGX: begin
                  if (!b[7]) begin
                     phase_in = btlv_pkg::PH_LEN1;
                  end
               end
               btlv_pkg::PH_EOC2: begin
                  if (b == 8'd0) begin
                     if (e_level == '0) begin
                        rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_DONE, 8'd0, 5'd0, 32'd0,
                                  e_start, 1'b0, e_count, btlv_pkg::ERR_NONE);
                        nrec = 2'd1;
                        phase_in = btlv_pkg::PH_HALT;
                     end else begin
                        do_close = 1'b1;
                     end
                  end else begin
                     tag_in = 8'd0;
                     lf     = 1'b1;
                  end
               end
               btlv_pkg::PH_LEN1: begin
                  lf = 1'b1;
               end
               btlv_pkg::PH_LENX: begin
                  acc_in  = acc_sh;
                  left_in = left_ff - LLW'(1);
                  if (acc_ff[31:24] != 8'd0) begin
                     rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_ERROR, e_tag, 5'(e_level),
                               e_start, 32'd0, 1'b0, e_count, btlv_pkg::ERR_LENGTH);
                     nrec = 2'd1;
                     phase_in = btlv_pkg::PH_HALT;
                  end else if (left_ff == LLW'(1)) begin
                     hd = 1'b1;
                  end
               end
               btlv_pkg::PH_CONTENT: begin
                  if (ipos_ff == 2'd1) begin
                     ifirst_in = b;
                     ipos_in   = 2'd2;
                  end else if (ipos_ff == 2'd2) begin
                     ipos_in = 2'd0;
                     fail3 = ((ifirst_ff == 8'd0) && !b[7])
                          || ((ifirst_ff == btlv_pkg::OCTET_ONES) && b[7]);
                  end
                  if (fail3) begin
                     rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_ERROR, e_tag, 5'(e_level),
                               e_start, 32'd0, 1'b0, cur_ff, btlv_pkg::ERR_INTEGER);
                     nrec = 2'd1;
                     phase_in = btlv_pkg::PH_HALT;
                  end else begin
                     acc_in = acc_ff - 32'd1;
                     fin    = (acc_ff == 32'd1);
                  end
               end
               btlv_pkg::PH_SCAN: begin
                  if (pz_ff && (b == 8'd0)) begin
                     pz_in    = 1'b0;
                     do_close = 1'b1;
                     eoc_at   = p - 32'd1;
                  end else begin
                     pz_in = (b == 8'd0);
                  end
               end
               default: begin
                  phase_in = btlv_pkg::PH_HALT;
               end
            endcase

            if (lf) begin
               if (b < btlv_pkg::LEN_INDEF) begin
                  hd = 1'b1;
               end else if (b == btlv_pkg::LEN_INDEF) begin
                  hd       = 1'b1;
                  hd_indef = 1'b1;
               end else if (int'(b[6:0]) > MAX_LEN_OCTETS) begin
                  rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_ERROR, e_tag, 5'(e_level), e_start,
                            32'd0, 1'b0, e_count, btlv_pkg::ERR_LENGTH);
                  nrec = 2'd1;
                  phase_in = btlv_pkg::PH_HALT;
               end else begin
                  left_in  = LLW'(b[6:0]);
                  acc_in   = 32'd0;
                  phase_in = btlv_pkg::PH_LENX;
               end
            end

            if (hd) begin
               pushes = constructed ? (hd_indef || (hd_len != 32'd0)) : hd_indef;
               if (e_count >= limit_ff) begin
                  rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_ERROR, e_tag, 5'(e_level), e_start,
                            32'd0, 1'b0, e_count, btlv_pkg::ERR_TABLE);
                  nrec = 2'd1;
                  phase_in = btlv_pkg::PH_HALT;
               end else if ((e_tag == btlv_pkg::TAG_NULL) && !hd_indef && (hd_len != 32'd0)) begin
                  rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_ERROR, e_tag, 5'(e_level), e_start,
                            32'd0, 1'b0, e_count, btlv_pkg::ERR_NULL);
                  nrec = 2'd1;
                  phase_in = btlv_pkg::PH_HALT;
               end else if (!hd_indef && over_h) begin
                  rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_ERROR, e_tag, 5'(e_level), e_start,
                            32'd0, 1'b0, e_count, btlv_pkg::ERR_OVERRUN);
                  nrec = 2'd1;
                  phase_in = btlv_pkg::PH_HALT;
               end else if (pushes && (e_level == LW'(MAX_DEPTH))) begin
                  rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_ERROR, e_tag, 5'(e_level), e_start,
                            32'd0, 1'b0, e_count, btlv_pkg::ERR_TOO_DEEP);
                  nrec = 2'd1;
                  phase_in = btlv_pkg::PH_HALT;
               end else begin
                  rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_HEADER, e_tag, 5'(e_level), e_start,
                            hd_indef ? 32'd0 : hd_len, hd_indef, e_count, btlv_pkg::ERR_NONE);
                  nrec     = 2'd1;
                  cur_in   = e_count;
                  count_in = e_count + 16'd1;
                  if (pushes) begin
                     push_en           = 1'b1;
                     push_data.end_off = hd_indef ? {1'b0, e_start} : bus.hend;
                     push_data.indef   = hd_indef;
                     push_data.tag     = e_tag;
                     push_data.entry   = e_count;
                     level_in          = e_level + LW'(1);
                     pz_in             = 1'b0;
                     phase_in = (hd_indef && !constructed) ? btlv_pkg::PH_SCAN
                                                           : btlv_pkg::PH_ID;
                  end else if (!constructed && (hd_len != 32'd0)) begin
                     acc_in   = hd_len;
                     ipos_in  = ((e_tag == btlv_pkg::TAG_INTEGER) && (hd_len > 32'd1)) ? 2'd1
                                                                                      : 2'd0;
                     phase_in = btlv_pkg::PH_CONTENT;
                  end else begin
                     fin = 1'b1;
                  end
               end
            end

            if (do_close) begin
               rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_CLOSED, top_e.tag, 5'(t_level),
                         top_e.end_off[31:0], eoc_at - top_e.end_off[31:0], 1'b1, top_e.entry,
                         btlv_pkg::ERR_NONE);
               nrec = 2'd1;
               fin  = 1'b1;
            end

            if (fin) begin
               level_in = new_level;
               if ((new_level == '0) && (total_ff != 32'd0) && (q == {1'b0, total_ff})) begin
                  if (nrec == 2'd0) begin
                     rec0 = btlv_pkg::make_rec(btlv_pkg::KIND_DONE, 8'd0, 5'd0, 32'd0,
                               total_ff, 1'b0, count_in, btlv_pkg::ERR_NONE);
                     nrec = 2'd1;
                  end else begin
                     rec1 = btlv_pkg::make_rec(btlv_pkg::KIND_DONE, 8'd0, 5'd0, 32'd0,
                               total_ff, 1'b0, count_in, btlv_pkg::ERR_NONE);
                     nrec = 2'd2;
                  end
                  phase_in = btlv_pkg::PH_HALT;
               end else begin
                  phase_in = btlv_pkg::PH_ID;
               end
            end
         end
      end
      if (nrec == 2'd1) begin
         rec0.last = 1'b1;
      end
      if (nrec == 2'd2) begin
         rec1.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= btlv_pkg::PH_ID;
         tag_ff    <= '0;
         left_ff   <= '0;
         acc_ff    <= '0;
         off_ff    <= '0;
         start_ff  <= '0;
         level_ff  <= '0;
         count_ff  <= '0;
         pz_ff     <= 1'b0;
         ipos_ff   <= '0;
         ifirst_ff <= '0;
         cur_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         left_ff   <= left_in;
         acc_ff    <= acc_in;
         off_ff    <= off_in;
         start_ff  <= start_in;
         level_ff  <= level_in;
         count_ff  <= count_in;
         pz_ff     <= pz_in;
         ipos_ff   <= ipos_in;
         ifirst_ff <= ifirst_in;
         cur_ff    <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 32'd0;
         limit_ff <= 16'hFFFF;
      end else if (csr_wen) begin
         if (csr_index == 1'b0) begin
            total_ff <= csr_wdata;
         end else begin
            limit_ff <= csr_wdata[15:0];
         end
      end
   end

   btlv_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_rec0   (rec0),
      .in_rec1   (rec1),
      .in_count  (accept ? nrec : 2'd0),
      .room      (q_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   assign req_tready = q_room;
   assign rsp_tuser  = out_rec.kind;
   assign rsp_tlast  = out_rec.last;
   assign rsp_tdata  = {7'd0, out_rec.err, out_rec.idx, out_rec.indef, out_rec.len,
                        out_rec.offset, out_rec.nest, out_rec.tag};

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(MAX_DEPTH))
      else $error("nesting level beyond stack depth");

   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == btlv_pkg::PH_HALT) && !(accept && req_tuser) |=> phase_ff == btlv_pkg::PH_HALT)
      else $error("parser left halt without a start word");

   a_content_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == btlv_pkg::PH_CONTENT) |-> (acc_ff != 32'd0))
      else $error("content phase with no bytes left");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      accept && (rec0.kind == btlv_pkg::KIND_ERROR) && (nrec != 2'd0) |-> nrec == 2'd1)
      else $error("error record followed by another record");

endmodule

### test/tb_ber_tlv_stream_parser.sv
// Self-checking testbench for ber_tlv_stream_parser: directed rows, then random BER encodings.
// Every record is compared with an in-bench prediction of the parser or with a directed row's typed expectation.
// Depends on btlv_pkg and the design folder only.
module tb_ber_tlv_stream_parser;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] octet_q_type[$];

   localparam logic CSR_TOTAL = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;
   localparam longint unsigned NO_BOUND = 64'hFFFF_FFFF_FFFF_FFFF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wen = 1'b0;
   logic         csr_index = 1'b0;
   logic [31:0]  csr_wdata = '0;

   ber_tlv_stream_parser i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted parser state.
   logic [31:0]          budget;
   logic [15:0]          table_cap;
   btlv_pkg::phase_type  pstate;
   logic [7:0]           cur_tag;
   int unsigned          len_octets;
   longint unsigned      len_acc;
   logic [31:0]          offset_ctr;
   logic [31:0]          hdr_start;
   longint unsigned      lvl_end [btlv_pkg::MaxDepth];
   logic                 lvl_indef[btlv_pkg::MaxDepth];
   logic [7:0]           lvl_tag  [btlv_pkg::MaxDepth];
   logic [15:0]          lvl_entry[btlv_pkg::MaxDepth];
   int unsigned          depth;
   logic [15:0]          entries;
   logic                 saw_zero;
   int unsigned          int_pos;
   logic [7:0]           int_first;
   logic [15:0]          open_entry;

   btlv_pkg::rec_type expected_records[$];
   btlv_pkg::rec_type byte_records[$];
   int      errors = 0;
   int      records_seen = 0;
   int      bytes_sent = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;

   function automatic void clear_parse();
      pstate = btlv_pkg::PH_ID; cur_tag = 0; len_octets = 0; len_acc = 0;
      offset_ctr = 0; hdr_start = 0; depth = 0; entries = 0;
      saw_zero = 0; int_pos = 0; int_first = 0; open_entry = 0;
   endfunction

   function automatic void add_record(logic [1:0] kind, logic [7:0] tag, int unsigned lvl,
                                      longint unsigned off, longint unsigned len,
                                      logic indef, logic [15:0] idx, logic [2:0] err);
      btlv_pkg::rec_type r;
      if (byte_records.size() >= 3) return;
      r.kind = kind; r.tag = tag; r.nest = lvl[4:0]; r.offset = off[31:0];
      r.len = len[31:0]; r.indef = indef; r.idx = idx; r.err = err; r.last = 1'b0;
      byte_records.push_back(r);
   endfunction

   function automatic void abort_parse(logic [2:0] code, logic [15:0] idx);
      add_record(btlv_pkg::KIND_ERROR, cur_tag, depth, hdr_start, 0, 0, idx, code);
      pstate = btlv_pkg::PH_HALT;
   endfunction

   function automatic longint unsigned limit_now();
      longint unsigned b = NO_BOUND;
      if (budget != 0) b = budget;
      for (int i = 0; i < depth; i++)
         if (!lvl_indef[i] && lvl_end[i] < b) b = lvl_end[i];
      return b;
   endfunction

   function automatic void item_ended(longint unsigned q);
      while (depth > 0 && !lvl_indef[depth-1] && lvl_end[depth-1] == q) depth--;
      if (depth == 0 && budget != 0 && q == budget) begin
         add_record(btlv_pkg::KIND_DONE, 0, 0, 0, budget, 0, entries, btlv_pkg::ERR_NONE);
         pstate = btlv_pkg::PH_HALT;
      end else begin
         pstate = btlv_pkg::PH_ID;
      end
   endfunction

   function automatic void close_level(logic [31:0] eoc_at, longint unsigned q);
      int unsigned t = depth - 1;
      logic [31:0] start_off = lvl_end[t][31:0];
      add_record(btlv_pkg::KIND_CLOSED, lvl_tag[t], t, start_off, eoc_at - start_off, 1,
                 lvl_entry[t], btlv_pkg::ERR_NONE);
      depth = t;
      item_ended(q);
   endfunction

   function automatic void header_complete(longint unsigned len, logic indef,
                                           longint unsigned q);
      logic cons = cur_tag[5];
      logic push = cons ? (indef || len > 0) : indef;
      if (entries >= table_cap) begin abort_parse(btlv_pkg::ERR_TABLE, entries); return; end
      if (cur_tag == btlv_pkg::TAG_NULL && !indef && len != 0) begin
         abort_parse(btlv_pkg::ERR_NULL, entries); return;
      end
      if (!indef && q + len > limit_now()) begin
         abort_parse(btlv_pkg::ERR_OVERRUN, entries); return;
      end
      if (push && depth >= btlv_pkg::MaxDepth) begin
         abort_parse(btlv_pkg::ERR_TOO_DEEP, entries); return;
      end
      add_record(btlv_pkg::KIND_HEADER, cur_tag, depth, hdr_start, indef ? 0 : len, indef,
                 entries, btlv_pkg::ERR_NONE);
      open_entry = entries;
      entries++;
      if (push) begin
         lvl_end[depth] = indef ? longint'(hdr_start) : q + len;
         lvl_indef[depth] = indef;
         lvl_tag[depth] = cur_tag;
         lvl_entry[depth] = open_entry;
         depth++;
         saw_zero = 0;
         pstate = (indef && !cons) ? btlv_pkg::PH_SCAN : btlv_pkg::PH_ID;
      end else if (!cons && len > 0) begin
         len_acc = len;
         int_pos = (cur_tag == btlv_pkg::TAG_INTEGER && len > 1) ? 1 : 0;
         pstate = btlv_pkg::PH_CONTENT;
      end else begin
         item_ended(q);
      end
   endfunction

   function automatic void first_length(logic [7:0] b, longint unsigned q);
      if (b < btlv_pkg::LEN_INDEF) header_complete(b, 0, q);
      else if (b == btlv_pkg::LEN_INDEF) header_complete(0, 1, q);
      else if (b[6:0] > btlv_pkg::MaxLenOctets) abort_parse(btlv_pkg::ERR_LENGTH, entries);
      else begin
         len_octets = b[6:0];
         len_acc = 0;
         pstate = btlv_pkg::PH_LENX;
      end
   endfunction

   // Advances the predicted parser by one byte; records land in byte_records.
   function automatic void parse_byte(logic [7:0] b, logic start);
      logic [31:0] p;
      longint unsigned q;
      byte_records.delete();
      if (start) clear_parse();
      if (pstate == btlv_pkg::PH_HALT) return;
      p = offset_ctr;
      q = longint'(p) + 1;
      offset_ctr = p + 1;
      if (longint'(p) >= limit_now()) begin
         abort_parse(btlv_pkg::ERR_OVERRUN, pstate == btlv_pkg::PH_CONTENT ? open_entry
                                                                           : entries);
      end else begin
         case (pstate)
            btlv_pkg::PH_ID: begin
               hdr_start = p;
               cur_tag = b;
               if (b == 0 && (depth > 0 ? lvl_indef[depth-1] : budget == 0))
                  pstate = btlv_pkg::PH_EOC2;
               else pstate = (b[4:0] == 5'h1F) ? btlv_pkg::PH_TAGX : btlv_pkg::PH_LEN1;
            end
            btlv_pkg::PH_EOC2: begin
               if (b == 0) begin
                  if (depth == 0) begin
                     add_record(btlv_pkg::KIND_DONE, 0, 0, 0, hdr_start, 0, entries,
                                btlv_pkg::ERR_NONE);
                     pstate = btlv_pkg::PH_HALT;
                  end else begin
                     close_level(hdr_start, q);
                  end
               end else begin
                  cur_tag = 0;
                  first_length(b, q);
               end
            end
            btlv_pkg::PH_TAGX: if (!b[7]) pstate = btlv_pkg::PH_LEN1;
            btlv_pkg::PH_LEN1: first_length(b, q);
            btlv_pkg::PH_LENX: begin
               len_acc = (len_acc << 8) | b;
               if (len_octets > 0) len_octets--;
               if (len_acc > 64'hFFFF_FFFF) abort_parse(btlv_pkg::ERR_LENGTH, entries);
               else if (len_octets == 0) header_complete(len_acc, 0, q);
            end
            btlv_pkg::PH_CONTENT: begin
               logic bad = 0;
               if (int_pos == 1) begin
                  int_first = b;
                  int_pos = 2;
               end else if (int_pos == 2) begin
                  int_pos = 0;
                  bad = (int_first == 0 && !b[7]) ||
                        (int_first == btlv_pkg::OCTET_ONES && b[7]);
               end
               if (bad) abort_parse(btlv_pkg::ERR_INTEGER, open_entry);
               else begin
                  if (len_acc > 0) len_acc--;
                  if (len_acc == 0) item_ended(q);
               end
            end
            btlv_pkg::PH_SCAN: begin
               if (saw_zero && b == 0) begin
                  saw_zero = 0;
                  close_level(p - 1, q);
               end else begin
                  saw_zero = (b == 0);
               end
            end
            default: pstate = btlv_pkg::PH_HALT;
         endcase
      end
      if (byte_records.size() > 0) byte_records[byte_records.size()-1].last = 1'b1;
   endfunction

   task automatic wait_idle();
      wait (expected_records.size() == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      @(negedge clock);
      csr_wen = 1'b1; csr_index = idx; csr_wdata = value;
      @(negedge clock);
      csr_wen = 1'b0;
      if (idx == CSR_TOTAL) budget = value;
      else table_cap = value[15:0];
   endtask

   // Sends one word; a typed expectation, when given, replaces the predicted record.
   task automatic send_byte(logic [7:0] b, logic start, logic typed,
                            btlv_pkg::rec_type typed_rec);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1; req_tdata = b; req_tuser = start;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      bytes_sent++;
      parse_byte(b, start);
      if (typed) begin
         typed_rec.last = 1'b1;
         expected_records.push_back(typed_rec);
      end else begin
         foreach (byte_records[i]) expected_records.push_back(byte_records[i]);
      end
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   always @(negedge clock) rsp_tready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         btlv_pkg::rec_type got, want;
         got.kind = rsp_tuser; got.tag = rsp_tdata[7:0]; got.nest = rsp_tdata[12:8];
         got.offset = rsp_tdata[44:13]; got.len = rsp_tdata[76:45]; got.indef = rsp_tdata[77];
         got.idx = rsp_tdata[93:78]; got.err = rsp_tdata[96:94]; got.last = rsp_tlast;
         records_seen++;
         if (expected_records.size() == 0) begin
            $error("record with nothing expected: kind %0d tag %h", got.kind, got.tag);
            errors++;
         end else begin
            want = expected_records.pop_front();
            if (got.kind != want.kind) begin
               $error("record_kind exp %0d got %0d", want.kind, got.kind); errors++;
            end
            if (got.tag != want.tag) begin
               $error("tag_byte exp %h got %h", want.tag, got.tag); errors++;
            end
            if (got.nest != want.nest) begin
               $error("nest_level exp %0d got %0d", want.nest, got.nest); errors++;
            end
            if (got.offset != want.offset) begin
               $error("item_offset exp %0d got %0d", want.offset, got.offset); errors++;
            end
            if (got.len != want.len) begin
               $error("content_length exp %0d got %0d", want.len, got.len); errors++;
            end
            if (got.indef != want.indef) begin
               $error("indefinite exp %0d got %0d", want.indef, got.indef); errors++;
            end
            if (got.idx != want.idx) begin
               $error("entry_index exp %0d got %0d", want.idx, got.idx); errors++;
            end
            if (got.err != want.err) begin
               $error("error_code exp %0d got %0d", want.err, got.err); errors++;
            end
            if (got.last != want.last) begin
               $error("last exp %0d got %0d", want.last, got.last); errors++;
            end
         end
      end
   end

   function automatic octet_q_type length_field(int unsigned n);
      octet_q_type f;
      case ($urandom_range(3))
         0: f = {8'h81, n[7:0]};
         1: f = {8'h82, n[15:8], n[7:0]};
         default: if (n < 128) f = {n[7:0]}; else f = {8'h81, n[7:0]};
      endcase
      return f;
   endfunction

   // Builds one item with random content, nesting up to three levels; random integer content may be non-minimal.
   function automatic octet_q_type make_item(int lvl);
      octet_q_type body, hdr;
      logic [7:0] tag;
      logic indef = ($urandom_range(4) == 0);
      if (lvl < 3 && $urandom_range(99) < 40) begin
         tag = ($urandom_range(1) == 0) ? 8'h30 : 8'hA1;
         repeat ($urandom_range(3)) body = {body, make_item(lvl + 1)};
         if (indef) body = {body, 8'h00, 8'h00};
      end else begin
         case ($urandom_range(4))
            0: begin
               tag = btlv_pkg::TAG_INTEGER;
               body = {8'($urandom_range(255))};
               repeat ($urandom_range(3)) body.push_back(8'($urandom_range(255)));
            end
            1: tag = btlv_pkg::TAG_NULL;
            default: begin
               tag = ($urandom_range(1) == 0) ? 8'h04 : 8'($urandom_range(1, 30) & 8'hDF);
               repeat ($urandom_range(6)) body.push_back(8'($urandom_range(1, 255)));
            end
         endcase
         if (indef) body = {body, 8'h00, 8'h00};
      end
      if ($urandom_range(9) == 0 && !tag[5]) hdr = {8'h1F, 8'h81, 8'h05};
      else hdr = {tag};
      if (indef) hdr.push_back(btlv_pkg::LEN_INDEF);
      else hdr = {hdr, length_field(body.size())};
      return {hdr, body};
   endfunction

   typedef struct {
      logic              cfg;
      logic              cfg_idx;
      logic [31:0]       cfg_val;
      logic [7:0]        data;
      logic              start;
      logic              typed;
      btlv_pkg::rec_type exp;
   } stim_row_type;

   function automatic btlv_pkg::rec_type rr(logic [1:0] k, logic [7:0] t, logic [4:0] n,
                                            logic [31:0] o, logic [31:0] l, logic ind,
                                            logic [15:0] i, logic [2:0] e);
      btlv_pkg::rec_type r;
      r.kind = k; r.tag = t; r.nest = n; r.offset = o; r.len = l;
      r.indef = ind; r.idx = i; r.err = e; r.last = 1'b1;
      return r;
   endfunction

   initial begin
      #5ms;
      $display("ber_tlv_stream_parser verification failed");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      btlv_pkg::rec_type none;
      octet_q_type enc;
      int encodings = 0;
      logic paused = 0;
      none = '0;
      budget = 0; table_cap = 16'hFFFF;
      clear_parse();
      rows = '{
         '{0, 0, 0, 8'h30, 1, 0, none},
         '{0, 0, 0, 8'h03, 0, 1, rr(btlv_pkg::KIND_HEADER, 8'h30, 0, 0, 3, 0, 0,
                                    btlv_pkg::ERR_NONE)},
         '{0, 0, 0, 8'h02, 0, 0, none},
         '{0, 0, 0, 8'h01, 0, 1, rr(btlv_pkg::KIND_HEADER, 8'h02, 1, 2, 1, 0, 1,
                                    btlv_pkg::ERR_NONE)},
         '{0, 0, 0, 8'hFF, 0, 0, none},
         '{0, 0, 0, 8'h02, 0, 0, none},
         '{0, 0, 0, 8'h02, 0, 0, none},
         '{0, 0, 0, 8'h00, 0, 0, none},
         '{0, 0, 0, 8'h01, 0, 1, rr(btlv_pkg::KIND_ERROR, 8'h02, 0, 5, 0, 0, 2,
                                    btlv_pkg::ERR_INTEGER)},
         '{0, 0, 0, 8'h05, 1, 0, none},
         '{0, 0, 0, 8'h01, 0, 1, rr(btlv_pkg::KIND_ERROR, btlv_pkg::TAG_NULL, 0, 0, 0, 0, 0,
                                    btlv_pkg::ERR_NULL)},
         '{0, 0, 0, 8'h04, 1, 0, none},
         '{0, 0, 0, 8'h85, 0, 1, rr(btlv_pkg::KIND_ERROR, 8'h04, 0, 0, 0, 0, 0,
                                    btlv_pkg::ERR_LENGTH)},
         '{0, 0, 0, 8'h3F, 1, 0, none},
         '{0, 0, 0, 8'h81, 0, 0, none},
         '{0, 0, 0, 8'h01, 0, 0, none},
         '{0, 0, 0, 8'h80, 0, 0, none},
         '{0, 0, 0, 8'h04, 0, 0, none},
         '{0, 0, 0, 8'h80, 0, 0, none},
         '{0, 0, 0, 8'h00, 0, 0, none},
         '{0, 0, 0, 8'h00, 0, 0, none},
         '{0, 0, 0, 8'h00, 0, 0, none},
         '{0, 0, 0, 8'h00, 0, 0, none},
         '{0, 0, 0, 8'h00, 0, 0, none},
         '{0, 0, 0, 8'h00, 0, 1, rr(btlv_pkg::KIND_DONE, 0, 0, 0, 10, 0, 2,
                                    btlv_pkg::ERR_NONE)},
         '{0, 0, 0, 8'h77, 0, 0, none},
         '{1, CSR_LIMIT, 0, 8'h05, 1, 0, none},
         '{0, 0, 0, 8'h00, 0, 1, rr(btlv_pkg::KIND_ERROR, btlv_pkg::TAG_NULL, 0, 0, 0, 0, 0,
                                    btlv_pkg::ERR_TABLE)},
         '{1, CSR_LIMIT, 32'hFFFF, 8'h05, 1, 0, none},
         '{1, CSR_TOTAL, 2, 8'h05, 1, 0, none},
         '{0, 0, 0, 8'h00, 0, 0, none},
         '{1, CSR_TOTAL, 1, 8'h05, 1, 0, none},
         '{0, 0, 0, 8'h00, 0, 1, rr(btlv_pkg::KIND_ERROR, btlv_pkg::TAG_NULL, 0, 0, 0, 0, 0,
                                    btlv_pkg::ERR_OVERRUN)},
         '{1, CSR_TOTAL, 32'hFFFF_FFFF, 8'h04, 1, 0, none},
         '{0, 0, 0, 8'h84, 0, 0, none},
         '{0, 0, 0, 8'hFF, 0, 0, none},
         '{0, 0, 0, 8'hFF, 0, 0, none}
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (rows[i]) begin
         if (rows[i].cfg) begin
            wait_idle();
            write_csr(rows[i].cfg_idx, rows[i].cfg_val);
         end
         send_byte(rows[i].data, rows[i].start, rows[i].typed, rows[i].exp);
      end
      wait_idle();
      write_csr(CSR_TOTAL, 32'd0);
      while (bytes_sent < 250) begin
         case ((encodings / 5) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         enc.delete();
         if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 12)) enc.push_back(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(1, 3)) enc = {enc, make_item(0)};
            if ($urandom_range(9) == 0) enc[$urandom_range(enc.size() - 1)] = 8'($urandom);
         end
         if (encodings % 7 == 3) begin
            wait_idle();
            write_csr(CSR_LIMIT, (encodings % 14 == 3) ? 32'($urandom_range(4)) : 32'hFFFF);
         end
         if ($urandom_range(2) == 0) begin
            wait_idle();
            write_csr(CSR_TOTAL, 32'(enc.size() + $urandom_range(1) - (enc.size() > 1)));
         end else begin
            enc = {enc, 8'h00, 8'h00};
            if (budget != 0) begin
               wait_idle();
               write_csr(CSR_TOTAL, 32'd0);
            end
         end
         foreach (enc[i]) begin
            if (!paused && encodings == 12 && i == enc.size() / 2) begin
               req_tvalid = 1'b0;
               wait_idle();
               paused = 1;
            end
            send_byte(enc[i], i == 0, 0, none);
         end
         encodings++;
      end
      req_tvalid = 1'b0;
      wait (expected_records.size() == 0);
      repeat (20) @(negedge clock);
      $display("Sent %0d words: directed rows and %0d random encodings; %0d records checked.",
               bytes_sent, encodings, records_seen);
      if (errors == 0 && expected_records.size() == 0) begin
         $display("ber_tlv_stream_parser verification clean");
      end else begin
         $display("ber_tlv_stream_parser verification failed");
      end
      $finish;
   end
endmodule
